[rtl/chip8_instruction_executor_assert.svh]
// Assertion macros shared by the executor RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define C8X_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("executor assertion failed");

// Condition holds in the cycle after the trigger.
`define C8X_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("executor assertion failed");

`endif

[rtl/c8x_pkg.sv]
// Shared types, constants and tables of the CHIP-8 instruction executor.
// No dependencies; c8x_if, c8x_exec and chip8_instruction_executor use it.
package c8x_pkg;

  // MEM_BYTES is a power of two, so address wrap is a truncation.
  localparam int MEM_BYTES  = 4096;
  localparam int MEM_AW     = $clog2(MEM_BYTES);
  localparam int PROG_START = 512;
  localparam int NUM_REGS   = 16;
  localparam int NUM_KEYS   = 16;
  localparam int REG_AW     = $clog2(NUM_REGS);
  localparam int FONT_BYTES = 80;
  localparam logic [REG_AW-1:0] FLAG_REG = REG_AW'(NUM_REGS - 1);

  localparam logic [1:0] KIND_EXEC   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [3:0] GRP_JUMP    = 4'h1;
  localparam logic [3:0] GRP_SKEQ_NN = 4'h3;
  localparam logic [3:0] GRP_SKNE_NN = 4'h4;
  localparam logic [3:0] GRP_SKEQ_VY = 4'h5;
  localparam logic [3:0] GRP_LOAD_NN = 4'h6;
  localparam logic [3:0] GRP_ADD_NN  = 4'h7;
  localparam logic [3:0] GRP_ALU     = 4'h8;
  localparam logic [3:0] GRP_SKNE_VY = 4'h9;
  localparam logic [3:0] GRP_SET_I   = 4'hA;
  localparam logic [3:0] GRP_JUMP_V0 = 4'hB;
  localparam logic [3:0] GRP_RANDOM  = 4'hC;
  localparam logic [3:0] GRP_KEY     = 4'hE;
  localparam logic [3:0] GRP_MISC    = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_DOWN   = 8'h9E;
  localparam logic [7:0] KEY_UP     = 8'hA1;
  localparam logic [7:0] MISC_GET_DT = 8'h07;
  localparam logic [7:0] MISC_WAIT_K = 8'h0A;
  localparam logic [7:0] MISC_SET_DT = 8'h15;
  localparam logic [7:0] MISC_SET_ST = 8'h18;
  localparam logic [7:0] MISC_ADD_I  = 8'h1E;
  localparam logic [7:0] MISC_FONT   = 8'h29;
  localparam logic [7:0] MISC_BCD    = 8'h33;
  localparam logic [7:0] MISC_STORE  = 8'h55;
  localparam logic [7:0] MISC_LOAD   = 8'h65;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_BCD,
    MODE_STORE,
    MODE_LOAD
  } mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
  } step_t;

  typedef struct packed {
    logic [15:0] program_counter;
    logic [15:0] index_value;
    logic [15:0] opcode;
    logic        waiting;
    logic [7:0]  read_data;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
  } result_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] idx;
    logic [7:0]  delay;
    logic [7:0]  sound;
    logic        wr_x;
    logic [7:0]  x_val;
    logic        wr_f;
    logic [7:0]  f_val;
    mode_t       mode;
    logic [7:0]  bcd_h;
    logic [7:0]  bcd_t;
    logic [7:0]  bcd_o;
  } exec_t;

  localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] glyph_byte(input logic [MEM_AW-1:0] a);
    logic [7:0] g;
    g = 8'h00;
    for (int k = 0; k < FONT_BYTES; k++) begin
      if (a == MEM_AW'(k)) begin
        g = GLYPHS[k];
      end
    end
    return g;
  endfunction

endpackage

[rtl/c8x_if.sv]
// Valid/ready channel interfaces for step items and result items.
// Depends on c8x_pkg for the payload structs.
interface c8x_step_if;
  logic            valid;
  logic            ready;
  c8x_pkg::step_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface c8x_result_if;
  logic             valid;
  logic             ready;
  c8x_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/chip8_instruction_executor.sv]
// CHIP-8 instruction executor: sequencer around the byte memory and register file.
// Depends on c8x_pkg, c8x_if, c8x_ram, c8x_exec and the assertion header.
//
// Usage: step beats carry a kind (execute, write byte, read byte), an address,
// write data, the pressed-key mask and a random byte. Each step beat yields
// exactly one result beat with the PC, index, fetched opcode, waiting flag,
// read byte and both timer values after that item.
// An instruction takes two fetch reads, three register reads and up to two
// register writes; a BCD store writes three bytes, and a block store or load
// moves X+1 registers between the register file and memory, one at a time.
// One item is in work at a time; a new step beat is taken as soon as the
// sequencer is idle, even while the previous result waits for the receiver.
// A stalled receiver holds the finished result; the next one waits behind it.
// After reset the byte memory is loaded with the font and zero over all MEM_BYTES
// addresses and the registers are cleared; no step beat is taken then.
`include "chip8_instruction_executor_assert.svh"
module chip8_instruction_executor (
  input logic         clk,
  input logic         rst,
  c8x_step_if.sink    step,
  c8x_result_if.source result
);
  import c8x_pkg::*;

  typedef enum logic [16:0] {
    S_CLEAR = 17'b1 << 0,
    S_IDLE  = 17'b1 << 1,
    S_RD    = 17'b1 << 2,
    S_F1    = 17'b1 << 3,
    S_F2    = 17'b1 << 4,
    S_F3    = 17'b1 << 5,
    S_F4    = 17'b1 << 6,
    S_F5    = 17'b1 << 7,
    S_EXEC  = 17'b1 << 8,
    S_WX    = 17'b1 << 9,
    S_WF    = 17'b1 << 10,
    S_BCD   = 17'b1 << 11,
    S_STR   = 17'b1 << 12,
    S_STW   = 17'b1 << 13,
    S_LDR   = 17'b1 << 14,
    S_LDW   = 17'b1 << 15,
    S_OUT   = 17'b1 << 16
  } state_t;

  state_t state;
  logic [MEM_AW-1:0] clr;
  logic [15:0] pc;
  logic [15:0] index;
  logic [7:0]  delay;
  logic [7:0]  sound;
  logic [15:0] op;
  logic [7:0]  vx;
  logic [7:0]  vy;
  logic [7:0]  v0;
  logic [15:0] keys;
  logic [7:0]  rnd;
  logic [15:0] ibase;
  logic [3:0]  cnt;
  logic        waiting;
  logic [7:0]  rdata;
  logic [7:0]  x_val;
  logic [7:0]  f_val;
  logic        wr_f;
  mode_t       mode;
  logic [7:0]  bcd_h;
  logic [7:0]  bcd_t;
  logic [7:0]  bcd_o;
  logic        out_valid;
  result_t     out_data;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic              rf_we;
  logic [REG_AW-1:0] rf_addr;
  logic [7:0]        rf_wdata;
  logic [7:0]        rf_rdata;
  logic [15:0]       iaddr;
  logic [15:0]       pc_inc;
  logic [15:0]       item_addr;
  exec_t             ex;
  logic              step_acc;

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  c8x_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
    .clk(clk), .we(rf_we), .addr(rf_addr), .wdata(rf_wdata), .rdata(rf_rdata)
  );

  c8x_exec u_exec (
    .op(op), .vx(vx), .vy(vy), .v0(v0), .keys(keys), .rnd(rnd),
    .pc(pc), .idx(index), .delay(delay), .sound(sound), .ex(ex)
  );

  assign step.ready   = (state == S_IDLE);
  assign step_acc     = step.valid && step.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign iaddr        = ibase + {12'd0, cnt};
  assign pc_inc       = pc + 16'd1;
  assign item_addr    = {4'd0, step.data.address};

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = iaddr[MEM_AW-1:0];
    mem_wdata = rf_rdata;
    rf_we     = 1'b0;
    rf_addr   = cnt;
    rf_wdata  = x_val;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr;
        mem_wdata = glyph_byte(clr);
        rf_we     = (clr < MEM_AW'(NUM_REGS));
        rf_addr   = clr[REG_AW-1:0];
        rf_wdata  = 8'd0;
      end
      S_IDLE: begin
        mem_we    = step_acc && (step.data.kind == KIND_WRITE);
        mem_addr  = (step.data.kind == KIND_EXEC) ? pc[MEM_AW-1:0]
                                                  : item_addr[MEM_AW-1:0];
        mem_wdata = step.data.write_data;
      end
      S_F1: mem_addr = pc[MEM_AW-1:0];
      S_F2: begin
        mem_addr = pc_inc[MEM_AW-1:0];
        rf_addr  = mem_rdata[3:0];
      end
      S_F3: rf_addr = mem_rdata[7:4];
      S_F4: rf_addr = '0;
      S_WX: begin
        rf_we   = 1'b1;
        rf_addr = op[11:8];
      end
      S_WF: begin
        rf_we    = 1'b1;
        rf_addr  = FLAG_REG;
        rf_wdata = f_val;
      end
      S_BCD: begin
        mem_we = 1'b1;
        case (cnt)
          4'd0:    mem_wdata = bcd_h;
          4'd1:    mem_wdata = bcd_t;
          default: mem_wdata = bcd_o;
        endcase
      end
      S_STW: mem_we = 1'b1;
      S_LDW: begin
        rf_we    = 1'b1;
        rf_wdata = mem_rdata;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      pc        <= 16'(PROG_START);
      index     <= 16'd0;
      delay     <= 8'd0;
      sound     <= 8'd0;
      out_valid <= 1'b0;
      cnt       <= 4'd0;
    end else begin
      if (out_valid && result.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == MEM_AW'(MEM_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (step_acc) begin
            op      <= 16'd0;
            waiting <= 1'b0;
            rdata   <= 8'd0;
            keys    <= step.data.key_mask;
            rnd     <= step.data.random_byte;
            case (step.data.kind)
              KIND_EXEC: state <= S_F1;
              KIND_READ: state <= S_RD;
              default:   state <= S_OUT;
            endcase
          end
        end
        S_RD: begin
          rdata <= mem_rdata;
          state <= S_OUT;
        end
        S_F1: state <= S_F2;
        S_F2: begin
          op[15:8] <= mem_rdata;
          state    <= S_F3;
        end
        S_F3: begin
          op[7:0] <= mem_rdata;
          vx      <= rf_rdata;
          state   <= S_F4;
        end
        S_F4: begin
          vy    <= rf_rdata;
          state <= S_F5;
        end
        S_F5: begin
          v0    <= rf_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          pc      <= ex.pc;
          index   <= ex.idx;
          delay   <= ex.delay;
          sound   <= ex.sound;
          waiting <= (ex.pc == pc);
          ibase   <= index;
          x_val   <= ex.x_val;
          f_val   <= ex.f_val;
          wr_f    <= ex.wr_f;
          mode    <= ex.mode;
          bcd_h   <= ex.bcd_h;
          bcd_t   <= ex.bcd_t;
          bcd_o   <= ex.bcd_o;
          cnt     <= 4'd0;
          case (ex.mode)
            MODE_BCD:   state <= S_BCD;
            MODE_STORE: state <= S_STR;
            MODE_LOAD:  state <= S_LDR;
            default: begin
              if (ex.wr_x) begin
                state <= S_WX;
              end else if (ex.wr_f) begin
                state <= S_WF;
              end else begin
                state <= S_OUT;
              end
            end
          endcase
        end
        S_WX: state <= wr_f ? S_WF : S_OUT;
        S_WF: state <= S_OUT;
        S_BCD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd2) begin
            state <= S_OUT;
          end
        end
        S_STR: state <= S_STW;
        S_LDR: state <= S_LDW;
        S_STW, S_LDW: begin
          if (cnt == op[11:8]) begin
            state <= S_OUT;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= (state == S_STW) ? S_STR : S_LDR;
          end
        end
        S_OUT: begin
          if (!out_valid || result.ready) begin
            out_valid                <= 1'b1;
            out_data.program_counter <= pc;
            out_data.index_value     <= index;
            out_data.opcode          <= op;
            out_data.waiting         <= waiting;
            out_data.read_data       <= rdata;
            out_data.delay_value     <= delay;
            out_data.sound_value     <= sound;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `C8X_ASSERT_NEXT(a_exec_fetch, step_acc && (step.data.kind == KIND_EXEC), state == S_F1)
  `C8X_ASSERT_SAME(a_fetch_no_write, (state == S_F1) || (state == S_F2) || (state == S_F3),
                   !mem_we)
  `C8X_ASSERT_SAME(a_block_bound, (state == S_STW) || (state == S_LDW), cnt <= op[11:8])
  `C8X_ASSERT_SAME(a_block_mode, (state == S_STR) || (state == S_STW), mode == MODE_STORE)
  `C8X_ASSERT_NEXT(a_out_loaded, (state == S_OUT) && !out_valid, out_valid)
endmodule

[rtl/c8x_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/c8x_exec.sv]
// Instruction decode and execute: next PC, index, timers, register writes and memory mode.
// Depends on c8x_pkg.
module c8x_exec (
  input  logic [15:0]    op,
  input  logic [7:0]     vx,
  input  logic [7:0]     vy,
  input  logic [7:0]     v0,
  input  logic [15:0]    keys,
  input  logic [7:0]     rnd,
  input  logic [15:0]    pc,
  input  logic [15:0]    idx,
  input  logic [7:0]     delay,
  input  logic [7:0]     sound,
  output c8x_pkg::exec_t ex
);
  import c8x_pkg::*;

  logic [15:0] nxt;
  logic [15:0] skp;
  logic [7:0]  nn;
  logic [8:0]  sum;
  logic        down;
  logic [3:0]  low_key;
  logic [7:0]  rem;
  logic [3:0]  tens;
  logic [7:0]  hund;
  logic [7:0]  ones;

  assign nn   = op[7:0];
  assign nxt  = pc + 16'd2;
  assign skp  = pc + 16'd4;
  assign sum  = {1'b0, vx} + {1'b0, vy};
  assign down = (vx[7:4] == 4'd0) && keys[vx[3:0]];

  always_comb begin
    low_key = 4'd0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (keys[k]) begin
        low_key = 4'(k);
      end
    end
  end

  always_comb begin
    if (vx >= 8'd200) begin
      hund = 8'd2;
      rem  = vx - 8'd200;
    end else if (vx >= 8'd100) begin
      hund = 8'd1;
      rem  = vx - 8'd100;
    end else begin
      hund = 8'd0;
      rem  = vx;
    end
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 8'(k * 10)) begin
        tens = 4'(k);
      end
    end
    ones = rem - ({4'd0, tens} << 3) - ({4'd0, tens} << 1);
  end

  always_comb begin
    ex.pc    = nxt;
    ex.idx   = idx;
    ex.delay = delay;
    ex.sound = sound;
    ex.wr_x  = 1'b0;
    ex.x_val = 8'd0;
    ex.wr_f  = 1'b0;
    ex.f_val = 8'd0;
    ex.mode  = MODE_NONE;
    ex.bcd_h = hund;
    ex.bcd_t = {4'd0, tens};
    ex.bcd_o = ones;
    case (op[15:12])
      GRP_JUMP:    ex.pc = {4'd0, op[11:0]};
      GRP_SKEQ_NN: ex.pc = (vx == nn) ? skp : nxt;
      GRP_SKNE_NN: ex.pc = (vx != nn) ? skp : nxt;
      GRP_SKEQ_VY: ex.pc = (vx == vy) ? skp : nxt;
      GRP_SKNE_VY: ex.pc = (vx != vy) ? skp : nxt;
      GRP_LOAD_NN: begin
        ex.wr_x  = 1'b1;
        ex.x_val = nn;
      end
      GRP_ADD_NN: begin
        ex.wr_x  = 1'b1;
        ex.x_val = vx + nn;
      end
      GRP_ALU: begin
        case (op[3:0])
          ALU_MOV: begin
            ex.wr_x  = 1'b1;
            ex.x_val = vy;
          end
          ALU_OR: begin
            ex.wr_x  = 1'b1;
            ex.x_val = vx | vy;
          end
          ALU_AND: begin
            ex.wr_x  = 1'b1;
            ex.x_val = vx & vy;
          end
          ALU_XOR: begin
            ex.wr_x  = 1'b1;
            ex.x_val = vx ^ vy;
          end
          ALU_ADD: begin
            ex.wr_x  = 1'b1;
            ex.x_val = sum[7:0];
            ex.wr_f  = 1'b1;
            ex.f_val = {7'd0, sum[8]};
          end
          ALU_SUB: begin
            ex.wr_x  = 1'b1;
            ex.x_val = vx - vy;
            ex.wr_f  = 1'b1;
            ex.f_val = {7'd0, vx >= vy};
          end
          ALU_SHR: begin
            ex.wr_x  = 1'b1;
            ex.x_val = vy >> 1;
            ex.wr_f  = 1'b1;
            ex.f_val = {7'd0, vy[0]};
          end
          ALU_RSB: begin
            ex.wr_x  = 1'b1;
            ex.x_val = vy - vx;
            ex.wr_f  = 1'b1;
            ex.f_val = {7'd0, vy >= vx};
          end
          ALU_SHL: begin
            ex.wr_x  = 1'b1;
            ex.x_val = vy << 1;
            ex.wr_f  = 1'b1;
            ex.f_val = {7'd0, vy[7]};
          end
          default: ex.wr_x = 1'b0;
        endcase
      end
      GRP_SET_I:   ex.idx = {4'd0, op[11:0]};
      GRP_JUMP_V0: ex.pc = {4'd0, op[11:0]} + {8'd0, v0};
      GRP_RANDOM: begin
        ex.wr_x  = 1'b1;
        ex.x_val = rnd & nn;
      end
      GRP_KEY: begin
        if (nn == KEY_DOWN) begin
          ex.pc = down ? skp : nxt;
        end else if (nn == KEY_UP) begin
          ex.pc = down ? nxt : skp;
        end else begin
          ex.pc = pc;
        end
      end
      GRP_MISC: begin
        case (nn)
          MISC_GET_DT: begin
            ex.wr_x  = 1'b1;
            ex.x_val = delay;
          end
          MISC_WAIT_K: begin
            if (keys == 16'd0) begin
              ex.pc = pc;
            end else begin
              ex.wr_x  = 1'b1;
              ex.x_val = {4'd0, low_key};
            end
          end
          MISC_SET_DT: ex.delay = vx;
          MISC_SET_ST: ex.sound = vx;
          MISC_ADD_I:  ex.idx = idx + {8'd0, vx};
          MISC_FONT:   ex.idx = ({8'd0, vx} << 2) + {8'd0, vx};
          MISC_BCD:    ex.mode = MODE_BCD;
          MISC_STORE: begin
            ex.mode = MODE_STORE;
            ex.idx  = idx + {12'd0, op[11:8]} + 16'd1;
          end
          MISC_LOAD: begin
            ex.mode = MODE_LOAD;
            ex.idx  = idx + {12'd0, op[11:8]} + 16'd1;
          end
          default: ex.pc = pc;
        endcase
      end
      default: ex.pc = nxt;
    endcase
  end
endmodule
